// ===== src/pbpc_pkg.sv =====
// Package for the push button press classifier.
// Holds the phase and event codes, register indexes and reset values.
// Used by push_button_press_classifier; depends on nothing.
package pbpc_pkg;

  // Timestamp width inside the block
  localparam int unsigned TIME_WIDTH_DEF = 32;
  // Debounce window in milliseconds
  localparam int unsigned DEBOUNCE_MS = 50;

  // Field widths
  localparam int unsigned NOW_W = 32;
  localparam int unsigned THR_W = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NOTIFY_SHORT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOTIFY_LONG   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_START_MS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_END_MS   = 2'd3;

  // Register reset values
  localparam logic [THR_W-1:0] LONG_START_RST = 16'd1000;
  localparam logic [THR_W-1:0] LONG_END_RST   = 16'd2000;

  // Press phase
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DOWN = 2'd1,
    PH_LONG = 2'd2,
    PH_WAIT = 2'd3
  } phase_e;

  // Reported event
  typedef enum logic [1:0] {
    EV_NONE       = 2'd0,
    EV_SHORT      = 2'd1,
    EV_LONG_PEND  = 2'd2,
    EV_LONG       = 2'd3
  } event_e;

endpackage

// ===== src/push_button_press_classifier.sv =====
// Top level of the push button press classifier.
// Input register, one-pass phase machine and output register; uses pbpc_pkg.
//
// Each request carries one button sample (level and millisecond timestamp) and
// yields exactly one event code: no change, short press, long press pending or
// long press. A new sample is taken every clock cycle while in_stall_o is low;
// each result passes through the input register, then the output register,
// and the phase machine reads and updates its state once per sample as that
// sample leaves the input register. Presses and releases count after more than
// 50 ms since the last level change; elapsed time wraps at TimeWidth bits and a
// negative difference never passes a threshold. With both notify enables clear
// the block reports no change and keeps its state. Write configuration only
// while no sample is in flight.
module push_button_press_classifier #(
  parameter int unsigned TimeWidth = pbpc_pkg::TIME_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Sample channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             level_i,
  input  logic [pbpc_pkg::NOW_W-1:0]       now_ms_i,
  // Result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       event_res_o,
  // Configuration write port
  input  logic                             cfg_we_i,
  input  logic [pbpc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [pbpc_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  // Configuration registers
  logic                          notify_short_q;
  logic                          notify_long_q;
  logic [pbpc_pkg::THR_W-1:0]    long_start_q;
  logic [pbpc_pkg::THR_W-1:0]    long_end_q;

  // Input stage
  logic                          in_valid_q;
  logic                          level_q;
  logic [pbpc_pkg::NOW_W-1:0]    now_q;
  logic                          in_accept;
  logic                          advance;
  logic                          work;

  // Machine state
  pbpc_pkg::phase_e              phase_q, phase_d;
  logic [TimeWidth-1:0]          last_q, last_d;

  // Output stage
  logic                          out_valid_q;
  pbpc_pkg::event_e              event_q, event_d;

  // Elapsed time compares
  logic [TimeWidth-1:0]          now_w;
  logic [TimeWidth-1:0]          elapsed;
  logic                          over_debounce;
  logic                          over_start;
  logic                          over_end;
  logic                          enabled;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      notify_short_q <= 1'b1;
      notify_long_q  <= 1'b1;
      long_start_q   <= pbpc_pkg::LONG_START_RST;
      long_end_q     <= pbpc_pkg::LONG_END_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pbpc_pkg::REG_NOTIFY_SHORT:  notify_short_q <= cfg_wdata_i[0];
        pbpc_pkg::REG_NOTIFY_LONG:   notify_long_q  <= cfg_wdata_i[0];
        pbpc_pkg::REG_LONG_START_MS: long_start_q   <= cfg_wdata_i;
        pbpc_pkg::REG_LONG_END_MS:   long_end_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Handshake: advance the input stage when the output register is empty or being taken
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign work       = in_valid_q && advance;

  // Hold the sample in the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      level_q <= level_i;
      now_q   <= now_ms_i;
    end
  end

  // Fit the timestamp to the internal time width
  if (TimeWidth > pbpc_pkg::NOW_W) begin : g_now_wide
    assign now_w = {{(TimeWidth - pbpc_pkg::NOW_W){1'b0}}, now_q};
  end else begin : g_now_narrow
    assign now_w = now_q[TimeWidth-1:0];
  end

  // Wrapped elapsed time; a set top bit means negative and fails every compare
  assign elapsed = now_w - last_q;
  assign over_debounce = !elapsed[TimeWidth-1] &&
                         (elapsed > TimeWidth'(pbpc_pkg::DEBOUNCE_MS));
  assign over_start    = !elapsed[TimeWidth-1] && (elapsed > TimeWidth'(long_start_q));
  assign over_end      = !elapsed[TimeWidth-1] && (elapsed > TimeWidth'(long_end_q));
  assign enabled       = notify_short_q || notify_long_q;

  // Next phase and last change time
  always_comb begin
    phase_d = phase_q;
    last_d  = last_q;
    if (work && enabled) begin
      case (phase_q)
        pbpc_pkg::PH_IDLE: begin
          if (level_q) begin
            last_d = now_w;
            if (over_debounce) phase_d = pbpc_pkg::PH_DOWN;
          end
        end
        pbpc_pkg::PH_DOWN: begin
          if (!level_q) begin
            last_d = now_w;
            if (over_debounce) phase_d = pbpc_pkg::PH_IDLE;
          end else if (over_start) begin
            phase_d = pbpc_pkg::PH_LONG;
          end
        end
        pbpc_pkg::PH_LONG: begin
          if (over_end) phase_d = pbpc_pkg::PH_WAIT;
        end
        pbpc_pkg::PH_WAIT: begin
          if (!level_q) begin
            last_d = now_w;
            if (over_debounce) phase_d = pbpc_pkg::PH_IDLE;
          end
        end
        default: phase_d = pbpc_pkg::PH_IDLE;
      endcase
    end
  end

  // Event for the current sample
  always_comb begin
    event_d = pbpc_pkg::EV_NONE;
    if (enabled) begin
      case (phase_q)
        pbpc_pkg::PH_DOWN: begin
          if (!level_q) begin
            if (over_debounce) event_d = pbpc_pkg::EV_SHORT;
          end else if (over_start) begin
            event_d = pbpc_pkg::EV_LONG_PEND;
          end
        end
        pbpc_pkg::PH_LONG: begin
          if (over_end) event_d = pbpc_pkg::EV_LONG;
        end
        default: event_d = pbpc_pkg::EV_NONE;
      endcase
    end
  end

  // Update machine state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= pbpc_pkg::PH_IDLE;
      last_q  <= '0;
    end else begin
      phase_q <= phase_d;
      last_q  <= last_d;
    end
  end

  // Output register: load on advance, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (work) begin
      event_q <= event_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign event_res_o = event_q;

  // Long press report leaves the machine waiting for release
  a_long_to_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (work && event_d == pbpc_pkg::EV_LONG) |=> (phase_q == pbpc_pkg::PH_WAIT))
    else $error("long press not followed by release wait");

  // Short press returns to idle and records the release time
  a_short_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (work && event_d == pbpc_pkg::EV_SHORT) |=>
      (phase_q == pbpc_pkg::PH_IDLE && last_q == $past(now_w)))
    else $error("short press did not return to idle with release time");

  // With both enables clear the state holds
  a_disabled_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!notify_short_q && !notify_long_q) |=> ($stable(phase_q) && $stable(last_q)))
    else $error("state changed while notifications disabled");

  // A stalled sample stays in the input register
  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(now_q) && $stable(level_q)))
    else $error("input stage lost a stalled sample");

  // A processed sample always yields a valid result next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    work |=> out_valid_q)
    else $error("processed sample produced no result");

endmodule

// ===== bench/push_button_press_classifier_tb.sv =====
// Self-checking bench for push_button_press_classifier: button samples in, press events out.
// A clocked driver and monitor run against a built-in press predictor; uses pbpc_pkg.
module push_button_press_classifier_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TW = pbpc_pkg::TIME_WIDTH_DEF;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned HOLD_AT = 150;
  localparam int unsigned HOLD_LEN = 150;

  typedef struct packed {
    logic                       level;
    logic [pbpc_pkg::NOW_W-1:0] now_ms;
  } sample_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            in_valid_i = 1'b0;
  logic                            in_stall_o;
  logic                            level_i = 1'b0;
  logic [pbpc_pkg::NOW_W-1:0]      now_ms_i = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic [1:0]                      event_res_o;
  logic                            cfg_we_i = 1'b0;
  logic [pbpc_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [pbpc_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;

  push_button_press_classifier dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .level_i    (level_i),
    .now_ms_i   (now_ms_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .event_res_o(event_res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor copy of the press machine and its registers
  pbpc_pkg::phase_e           btn_phase = pbpc_pkg::PH_IDLE;
  logic [TW-1:0]              last_edge_ms = '0;
  logic                       notify_short_q = 1'b1;
  logic                       notify_long_q = 1'b1;
  logic [pbpc_pkg::THR_W-1:0] long_start_q = pbpc_pkg::LONG_START_RST;
  logic [pbpc_pkg::THR_W-1:0] long_end_q = pbpc_pkg::LONG_END_RST;

  sample_t          sample_q[$];
  pbpc_pkg::event_e press_events_q[$];
  sample_t          next_sample;
  pbpc_pkg::event_e want_event;
  logic [31:0]      clock_ms = '0;
  int unsigned      queued_cnt = 0;
  int unsigned      sent_cnt = 0;
  int unsigned      err_cnt = 0;
  int unsigned      quiet_cycles = 0;
  int unsigned      tx_idle_pct = 19;
  int unsigned      rx_idle_pct = 55;
  int unsigned      hold_left = 0;
  bit               hold_done = 1'b0;

  // Signed elapsed time since the last recorded change, strictly above a limit
  function automatic logic held_past(logic [TW-1:0] now_t, logic [TW-1:0] limit);
    logic [TW-1:0] span;
    span = now_t - last_edge_ms;
    return !span[TW-1] && (span > limit);
  endfunction

  function automatic pbpc_pkg::event_e classify_sample(logic lvl,
                                                       logic [pbpc_pkg::NOW_W-1:0] now);
    logic [TW-1:0]    now_t;
    logic             settled;
    pbpc_pkg::event_e ev;
    now_t = TW'(now);
    ev = pbpc_pkg::EV_NONE;
    if (notify_short_q || notify_long_q) begin
      case (btn_phase)
        pbpc_pkg::PH_IDLE: begin
          if (lvl) begin
            settled = held_past(now_t, TW'(pbpc_pkg::DEBOUNCE_MS));
            last_edge_ms = now_t;
            if (settled) btn_phase = pbpc_pkg::PH_DOWN;
          end
        end
        pbpc_pkg::PH_DOWN: begin
          if (!lvl) begin
            settled = held_past(now_t, TW'(pbpc_pkg::DEBOUNCE_MS));
            last_edge_ms = now_t;
            if (settled) begin
              ev = pbpc_pkg::EV_SHORT;
              btn_phase = pbpc_pkg::PH_IDLE;
            end
          end else if (held_past(now_t, TW'(long_start_q))) begin
            ev = pbpc_pkg::EV_LONG_PEND;
            btn_phase = pbpc_pkg::PH_LONG;
          end
        end
        pbpc_pkg::PH_LONG: begin
          if (held_past(now_t, TW'(long_end_q))) begin
            ev = pbpc_pkg::EV_LONG;
            btn_phase = pbpc_pkg::PH_WAIT;
          end
        end
        default: begin
          if (!lvl) begin
            settled = held_past(now_t, TW'(pbpc_pkg::DEBOUNCE_MS));
            last_edge_ms = now_t;
            if (settled) btn_phase = pbpc_pkg::PH_IDLE;
          end
        end
      endcase
    end
    return ev;
  endfunction

  // Sample driver: predict on accept, then offer the next request or idle
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      press_events_q.push_back(classify_sample(level_i, now_ms_i));
      sent_cnt++;
    end
    if (!in_valid_i || !in_stall_o) begin
      if (sample_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        next_sample = sample_q.pop_front();
        in_valid_i <= 1'b1;
        level_i <= next_sample.level;
        now_ms_i <= next_sample.now_ms;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Event monitor: check against the oldest prediction, drive receiver stall
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (press_events_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("ERROR: event %0d with none predicted", event_res_o);
      end else begin
        want_event = press_events_q.pop_front();
        if (event_res_o !== want_event) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("ERROR: event_res expected %s (%0d) got %0d",
                     want_event.name(), want_event, event_res_o);
        end
      end
    end
    // Hold off once for a long stretch so the block backs up
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (!hold_done && sent_cnt >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic add_sample(logic lvl, logic [31:0] t);
    sample_t s;
    s.level = lvl;
    s.now_ms = t;
    sample_q.push_back(s);
    queued_cnt++;
  endtask

  // One press: release gap, optional bounce, held samples, optional glitch, release
  task automatic add_press();
    int unsigned hold;
    int unsigned step;
    int unsigned kind;
    logic [31:0] t0;
    repeat ($urandom_range(0, 2)) begin
      clock_ms += $urandom_range(0, 120);
      add_sample(1'b0, clock_ms);
    end
    clock_ms += $urandom_range(0, 150);
    kind = $urandom_range(99);
    if (kind < 45) hold = $urandom_range(0, 200);
    else if (kind < 75) hold = $urandom_range(0, long_start_q + 100);
    else hold = long_start_q + $urandom_range(0, long_end_q + 300);
    step = hold / $urandom_range(2, 6) + 1;
    if ($urandom_range(2) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        add_sample(1'($urandom_range(1)), clock_ms);
        clock_ms += $urandom_range(1, 20);
      end
    end
    t0 = clock_ms;
    add_sample(1'b1, clock_ms);
    while (clock_ms - t0 < hold) begin
      clock_ms += $urandom_range(1, step);
      add_sample(1'b1, clock_ms);
    end
    if ($urandom_range(2) == 0) begin
      clock_ms += $urandom_range(1, 30);
      add_sample(1'b0, clock_ms);
      clock_ms += $urandom_range(1, 30);
      add_sample(1'b1, clock_ms);
    end
    clock_ms += $urandom_range(0, 80);
    add_sample(1'b0, clock_ms);
  endtask

  // Mostly well-formed presses, with timestamp jumps and random noise
  task automatic add_random(int unsigned n);
    int unsigned goal;
    int unsigned roll;
    goal = queued_cnt + n;
    while (queued_cnt < goal) begin
      roll = $urandom_range(99);
      if (roll < 10) begin
        add_sample(1'($urandom_range(1)), $urandom);
      end else if (roll < 13) begin
        clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
      end else if (roll < 15) begin
        clock_ms = $urandom;
      end else begin
        add_press();
      end
    end
  endtask

  task automatic write_reg(logic [pbpc_pkg::CFG_IDX_W-1:0] idx,
                           logic [pbpc_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      pbpc_pkg::REG_NOTIFY_SHORT:  notify_short_q = data[0];
      pbpc_pkg::REG_NOTIFY_LONG:   notify_long_q = data[0];
      pbpc_pkg::REG_LONG_START_MS: long_start_q = data;
      default:                     long_end_q = data;
    endcase
  endtask

  task automatic wait_drained();
    while (sample_q.size() != 0 || in_valid_i || press_events_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset settings: long press walk, bounces, wrap and negative elapsed
    tx_idle_pct = 19;
    rx_idle_pct = 55;
    add_sample(1'b1, 32'd0);    add_sample(1'b1, 32'd51);   add_sample(1'b1, 32'd1052);
    add_sample(1'b0, 32'd1500); add_sample(1'b1, 32'd2052); add_sample(1'b1, 32'd2060);
    add_sample(1'b0, 32'd2080); add_sample(1'b1, 32'd2100); add_sample(1'b1, 32'd2151);
    add_sample(1'b0, 32'd2160); add_sample(1'b0, 32'd2211);
    add_sample(1'b1, 32'hFFFF_FFFF); add_sample(1'b1, 32'h0000_0040);
    add_sample(1'b0, 32'h0000_0000); add_sample(1'b1, 32'h7FFF_FFFF);
    add_sample(1'b0, 32'h8000_0000); add_sample(1'b0, 32'hFFFF_FFFF);
    add_sample(1'b1, 32'd2001); add_sample(1'b1, 32'd2016); add_sample(1'b0, 32'd2051);
    add_sample(1'b1, 32'd2060); add_sample(1'b1, 32'd2200);
    clock_ms = 32'd3000;
    add_random(300);
    wait_drained();

    // Lowest thresholds, long enable only
    write_reg(pbpc_pkg::REG_NOTIFY_SHORT, 16'hFFFE);
    write_reg(pbpc_pkg::REG_NOTIFY_LONG, 16'h0001);
    write_reg(pbpc_pkg::REG_LONG_START_MS, 16'h0000);
    write_reg(pbpc_pkg::REG_LONG_END_MS, 16'h0000);
    add_random(150);
    wait_drained();

    // Highest thresholds, short enable only; swap idling sides
    tx_idle_pct = 55;
    rx_idle_pct = 19;
    write_reg(pbpc_pkg::REG_NOTIFY_SHORT, 16'hFFFF);
    write_reg(pbpc_pkg::REG_NOTIFY_LONG, 16'h0000);
    write_reg(pbpc_pkg::REG_LONG_START_MS, 16'hFFFF);
    write_reg(pbpc_pkg::REG_LONG_END_MS, 16'hFFFF);
    add_random(150);
    wait_drained();

    // Both enables clear: no events, state frozen
    write_reg(pbpc_pkg::REG_NOTIFY_SHORT, 16'h0000);
    add_random(60);
    wait_drained();

    // Both enables set, mid-range thresholds, no idling
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(pbpc_pkg::REG_NOTIFY_SHORT, 16'h0001);
    write_reg(pbpc_pkg::REG_NOTIFY_LONG, 16'h0001);
    write_reg(pbpc_pkg::REG_LONG_START_MS, 16'($urandom_range(100, 1500)));
    write_reg(pbpc_pkg::REG_LONG_END_MS, 16'($urandom_range(200, 3000)));
    add_random(300);
    wait_drained();

    // Fully random settings
    write_reg(pbpc_pkg::REG_NOTIFY_SHORT, 16'($urandom));
    write_reg(pbpc_pkg::REG_NOTIFY_LONG, 16'($urandom));
    write_reg(pbpc_pkg::REG_LONG_START_MS, 16'($urandom_range(0, 4000)));
    write_reg(pbpc_pkg::REG_LONG_END_MS, 16'($urandom));
    add_random(150);
    wait_drained();

    repeat (8) @(posedge clk_i);
    if (err_cnt == 0 && press_events_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/pbpc_pkg.sv
src/push_button_press_classifier.sv
bench/push_button_press_classifier_tb.sv
